@@ hdl/assert_macros.svh @@
// Assertion helpers shared by the RTL.
// Each macro expects signals named clk and arst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define ASSERT_ALWAYS(label, expr, msg)
`define ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

@@ hdl/ice_pkg.sv @@
package ice_pkg;

	localparam int WORD_W          = 16;
	localparam int BYTE_W          = 8;
	localparam int LENGTH_BITS_DEF = 16;
	localparam int PADDR_W         = 3;
	localparam int PDATA_W         = 32;

	localparam logic [WORD_W-1:0] UDP_PROTOCOL  = 16'd17;
	localparam logic [WORD_W-1:0] OFFSET_RESET  = 16'd10;

	// Register select taken from paddr[2] (registers sit 4 bytes apart)
	localparam logic REG_UDP_MODE    = 1'b0;
	localparam logic REG_CSUM_OFFSET = 1'b1;

	// Hand-over from the accumulate stage to the final combine stage
	typedef struct packed {
		logic [WORD_W-1:0] sum;
		logic [WORD_W-1:0] length;
		logic              udp;
	} final_req_t;

	// 16-bit ones'-complement add with end-around carry
	function automatic logic [WORD_W-1:0] ones_add(input logic [WORD_W-1:0] a,
			input logic [WORD_W-1:0] b);
		logic [WORD_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, s[WORD_W]};
	endfunction

endpackage

@@ hdl/ice_accum.sv @@
module ice_accum #(
	parameter int LENGTH_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [ice_pkg::BYTE_W-1:0]  s_tdata,
	input  logic                        s_tuser,
	input  logic                        s_tlast,
	input  logic                        udp_mode,
	input  logic [ice_pkg::WORD_W-1:0]  checksum_offset,
	output logic                        req_valid,
	input  logic                        req_ready,
	output ice_pkg::final_req_t         req
);
	import ice_pkg::*;

	localparam logic [LENGTH_BITS-1:0] CNT_MAX = '1;

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              pseudo_s1;
	logic              last_s1;

	logic [WORD_W-1:0]      acc_q;
	logic [BYTE_W-1:0]      pend_q;
	logic                   odd_q;
	logic [LENGTH_BITS-1:0] count_q;

	logic                   adv;
	logic                   counted;
	logic                   hit;
	logic [WORD_W:0]        offset_p1;
	logic [BYTE_W-1:0]      byte_eff;
	logic [WORD_W-1:0]      word;
	logic [WORD_W-1:0]      sum_w;
	logic [LENGTH_BITS-1:0] count_n;

	// A non-final byte only updates state; a final one needs room downstream.
	assign adv      = valid_s1 && (!last_s1 || req_ready);
	assign s_tready = !valid_s1 || adv;

	assign counted   = !pseudo_s1 && (count_q != CNT_MAX);
	assign offset_p1 = {1'b0, checksum_offset} + {{WORD_W{1'b0}}, 1'b1};
	assign hit       = counted && ((WORD_W'(count_q) == checksum_offset) ||
			({1'b0, WORD_W'(count_q)} == offset_p1));
	assign byte_eff  = hit ? '0 : byte_s1;
	// On an even position the byte can only be added now if it is the last
	// one, and then it is the high byte of a zero-padded word.
	assign word      = odd_q ? {pend_q, byte_eff} : {byte_eff, {BYTE_W{1'b0}}};
	assign sum_w     = ones_add(acc_q, word);
	assign count_n   = counted ? count_q + {{(LENGTH_BITS-1){1'b0}}, 1'b1} : count_q;

	assign req_valid  = valid_s1 && last_s1;
	assign req.sum    = sum_w;
	assign req.length = WORD_W'(count_n);
	assign req.udp    = udp_mode;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1   <= s_tdata;
			pseudo_s1 <= s_tuser;
			last_s1   <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			pend_q  <= '0;
			odd_q   <= 1'b0;
			count_q <= '0;
		end else if (adv) begin
			if (last_s1) begin
				acc_q   <= '0;
				pend_q  <= '0;
				odd_q   <= 1'b0;
				count_q <= '0;
			end else begin
				count_q <= count_n;
				if (odd_q) begin
					acc_q  <= sum_w;
					pend_q <= '0;
					odd_q  <= 1'b0;
				end else begin
					pend_q <= byte_eff;
					odd_q  <= 1'b1;
				end
			end
		end
	end

endmodule

@@ hdl/ice_final.sv @@
module ice_final (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  ice_pkg::final_req_t         req,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [2*ice_pkg::WORD_W-1:0] m_tdata
);
	import ice_pkg::*;

	logic        valid_s2;
	final_req_t  req_s2;
	logic        out_valid_q;
	logic [WORD_W-1:0] csum_q;
	logic [WORD_W-1:0] len_q;

	logic              out_free;
	logic [WORD_W+1:0] total;
	logic [WORD_W:0]   fold1;
	logic [WORD_W-1:0] fold2;
	logic [WORD_W-1:0] result;

	assign out_free  = !out_valid_q || m_tready;
	assign req_ready = !valid_s2 || out_free;

	// Three-term ones'-complement sum, folded twice to 16 bits
	assign total  = {2'b00, req_s2.sum} + {2'b00, UDP_PROTOCOL} + {2'b00, req_s2.length};
	assign fold1  = {1'b0, total[WORD_W-1:0]} + {{(WORD_W-1){1'b0}}, total[WORD_W+1:WORD_W]};
	assign fold2  = fold1[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, fold1[WORD_W]};
	assign result = req_s2.udp ? fold2 : req_s2.sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (req_valid && req_ready) begin
			valid_s2 <= 1'b1;
		end else if (out_free) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s2 <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s2) begin
			csum_q <= ~result;
			len_q  <= req_s2.length;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {len_q, csum_q};

endmodule

@@ hdl/internet_checksum_engine.sv @@
// Internet checksum engine: streams packet bytes and returns the 16-bit
// ones'-complement checksum of the region together with its counted length.
// Input channel (s_*): one byte per beat in s_tdata; s_tuser marks a
// pseudo-header address byte, which is summed but not counted; s_tlast marks
// the final byte of a packet region. Output channel (m_*): one beat per
// region, carrying the complemented folded sum and the saturating length.
// Configuration goes through the APB port: udp_mode at address 0 and
// checksum_offset at address 4. Write them only while no packet is in flight.
// Throughput is one byte per cycle while s_tready is high; the single 16-bit end-around
// add of the accumulate stage sets that figure. The edge that accepts the last byte
// of a region loads the input register; the combine register and then the output
// register take the result in turn, and the output register raises m_tvalid.
// Reset clears the running sum, pairing state and count, sets udp_mode to 0
// and checksum_offset to 10. When the receiver stalls, the result holds in
// the output register and the combine stage, and bytes keep being accepted
// until a further last byte finds no room; then s_tready drops.
module internet_checksum_engine #(
	parameter int LENGTH_BITS = ice_pkg::LENGTH_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Input stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [ice_pkg::BYTE_W-1:0]    s_tdata,  // [7:0] data_byte
	input  logic                          s_tuser,  // [0] pseudo_byte
	input  logic                          s_tlast,
	// Result stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [2*ice_pkg::WORD_W-1:0]  m_tdata,  // [15:0] checksum, [31:16] segment_length
	// APB configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ice_pkg::PADDR_W-1:0]   paddr,
	input  logic [ice_pkg::PDATA_W-1:0]   pwdata,
	output logic [ice_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);
	import ice_pkg::*;

`include "assert_macros.svh"

	logic              udp_mode_q;
	logic [WORD_W-1:0] csum_offset_q;
	logic              cfg_wr;

	logic       req_valid;
	logic       req_ready;
	final_req_t req;

	// The bus never waits; a write lands on the access cycle.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			udp_mode_q    <= 1'b0;
			csum_offset_q <= OFFSET_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_UDP_MODE:    udp_mode_q    <= pwdata[0];
				REG_CSUM_OFFSET: csum_offset_q <= pwdata[WORD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_UDP_MODE:    prdata = {{(PDATA_W-1){1'b0}}, udp_mode_q};
			REG_CSUM_OFFSET: prdata = {{(PDATA_W-WORD_W){1'b0}}, csum_offset_q};
			default:         prdata = '0;
		endcase
	end

	// Byte pairing, offset blanking, counting and the running sum.
	ice_accum #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_accum (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tuser         (s_tuser),
		.s_tlast         (s_tlast),
		.udp_mode        (udp_mode_q),
		.checksum_offset (csum_offset_q),
		.req_valid       (req_valid),
		.req_ready       (req_ready),
		.req             (req)
	);

	// UDP terms, folding, complement and the output register.
	ice_final u_final (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	// A finished region waiting for the combine stage must not be dropped.
	`ASSERT_NEXT(a_req_held, req_valid && !req_ready, req_valid, "final request dropped")
	// A last byte waiting for room always holds the input back.
	`ASSERT_ALWAYS(a_stall_need, !s_tready || !(req_valid && !req_ready), "input not held")
	// Input back-pressure only comes from a last byte waiting for room.
	`ASSERT_ALWAYS(a_stall_src, s_tready || (req_valid && !req_ready), "input stalled")
	// A draining output register always frees the combine stage.
	`ASSERT_ALWAYS(a_drain_ready, !m_tready || req_ready, "combine stage blocked")

endmodule
